[rtl/lsched_pkg.sv]
// ----------------------------------------------------------------------------
// lsched_pkg
// Shared types and constants of the lottery scheduler: transaction payloads,
// command codes and the control/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package lsched_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [4:0] DONE_CNT_MAX = 5'h1F;

  typedef struct packed {
    logic        command;
    logic [3:0]  slot_index;
    logic [15:0] arrive_at;
    logic [15:0] work_len;
    logic [7:0]  tickets;
    logic [30:0] random_value;
  } in_t;

  typedef struct packed {
    logic        cpu_busy;
    logic [3:0]  running_slot;
    logic        finished;
    logic [15:0] resp_ticks;
    logic [15:0] turn_ticks;
    logic        all_done;
    logic [15:0] tick_time;
  } out_t;

  typedef struct packed {
    logic accept;
    logic load_wr;
    logic sum_en;
    logic div_start;
    logic div_step;
    logic pick_init;
    logic pick_en;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic total_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/lsched_ram.sv]
// ----------------------------------------------------------------------------
// lsched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lsched_ctrl.sv]
// ----------------------------------------------------------------------------
// lsched_ctrl
// Controller of the lottery scheduler: sequences load, ticket sum, modulo,
// winner search, slot update and result hand-off.
// ----------------------------------------------------------------------------
module lsched_ctrl
  import lsched_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_command,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_LOAD) begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.walk_done) begin
          if (sts.total_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.pick_init = 1'b1;
          state_nxt     = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick_en = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/lsched_dp.sv]
// ----------------------------------------------------------------------------
// lsched_dp
// Datapath of the lottery scheduler: slot table RAM, tick counter, ticket
// accumulators, bit-serial modulo unit and the output register.
// ----------------------------------------------------------------------------
module lsched_dp
  import lsched_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_t        in_data,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int TOT_W  = $clog2(NUM_SLOTS * 255 + 1);
  localparam int WORD_W = 2 * TIME_BITS + 40;
  localparam int ARR_LO = 40;
  localparam int STA_LO = 40 + TIME_BITS;

  logic [4:0]           pcount_r;
  logic [TIME_BITS-1:0] time_r;
  logic [4:0]           done_cnt_r;
  logic                 tick_r;
  logic [30:0]          dvd_r;
  logic [4:0]           div_cnt_r;
  logic [TOT_W-1:0]     rem_r;
  logic [TOT_W-1:0]     total_r;
  logic [TOT_W-1:0]     acc_r;
  logic [CNT_W-1:0]     iss_r;
  logic                 rvld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [WORD_W-1:0]    pick_word_r;
  logic                 busy_r;
  logic [3:0]           slot_r;
  logic                 fin_r;
  logic [15:0]          resp_r;
  logic [15:0]          turn_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic [8:0]           n_wide;
  logic [CNT_W-1:0]     n;
  logic                 walking;
  logic                 issue;
  logic [WORD_W-1:0]    rd_data;
  logic [7:0]           rd_tickets;
  logic [15:0]          rd_remain;
  logic [TIME_BITS-1:0] rd_arrival;
  logic                 rd_elig;
  logic [TOT_W-1:0]     acc_sum;
  logic [TOT_W:0]       div_shift;
  logic [TOT_W:0]       div_diff;
  logic [8:0]           slot_wide;
  logic                 slot_ok;
  logic [TIME_BITS-1:0] ld_arrival;
  logic [7:0]           pk_tickets;
  logic [15:0]          pk_remain;
  logic [15:0]          pk_burst;
  logic [TIME_BITS-1:0] pk_arrival;
  logic [TIME_BITS-1:0] pk_start;
  logic [TIME_BITS-1:0] new_start;
  logic [15:0]          new_remain;
  logic [TIME_BITS-1:0] resp_t;
  logic [TIME_BITS-1:0] turn_t;
  logic [31:0]          resp_wide;
  logic [31:0]          turn_wide;
  logic [31:0]          time_wide;
  logic [8:0]           pick_wide;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_W-1:0]    wr_data;

  assign n_wide  = (9'(pcount_r) > 9'(NUM_SLOTS)) ? 9'(NUM_SLOTS) : 9'(pcount_r);
  assign n       = CNT_W'(n_wide);
  assign walking = cmd.sum_en || cmd.pick_en;
  assign issue   = walking && (iss_r < n);

  lsched_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(iss_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign rd_tickets = rd_data[7:0];
  assign rd_remain  = rd_data[23:8];
  assign rd_arrival = rd_data[ARR_LO +: TIME_BITS];
  assign rd_elig    = (rd_arrival <= time_r) && (rd_remain != 16'd0);
  assign acc_sum    = acc_r + (rd_elig ? TOT_W'(rd_tickets) : TOT_W'(0));

  assign div_shift = {rem_r, dvd_r[30]};
  assign div_diff  = div_shift - {1'b0, total_r};

  assign slot_wide  = 9'(in_data.slot_index);
  assign slot_ok    = slot_wide < 9'(NUM_SLOTS);
  assign ld_arrival = TIME_BITS'(32'(in_data.arrive_at));

  assign pk_tickets = pick_word_r[7:0];
  assign pk_remain  = pick_word_r[23:8];
  assign pk_burst   = pick_word_r[39:24];
  assign pk_arrival = pick_word_r[ARR_LO +: TIME_BITS];
  assign pk_start   = pick_word_r[STA_LO +: TIME_BITS];
  assign new_start  = (pk_remain == pk_burst) ? time_r : pk_start;
  assign new_remain = pk_remain - 16'd1;
  assign resp_t     = new_start - pk_arrival;
  assign turn_t     = time_r - pk_arrival;
  assign resp_wide  = 32'(resp_t);
  assign turn_wide  = 32'(turn_t);
  assign time_wide  = 32'(time_r);
  assign pick_wide  = 9'(pick_r);

  always_comb begin
    if (cmd.load_wr) begin
      wr_en   = slot_ok;
      wr_addr = slot_wide[IDX_W-1:0];
      wr_data = {TIME_BITS'(0), ld_arrival, in_data.work_len, in_data.work_len,
                 in_data.tickets};
    end else begin
      wr_en   = cmd.update && found_r;
      wr_addr = pick_r;
      wr_data = {new_start, pk_arrival, pk_burst, new_remain, pk_tickets};
    end
  end

  assign sts.walk_done  = (iss_r >= n) && !rvld_r;
  assign sts.total_zero = (total_r == TOT_W'(0));
  assign sts.div_done   = (div_cnt_r == 5'd30);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= 5'd0;
      time_r      <= '0;
      done_cnt_r  <= 5'd0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
      iss_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pcount_r <= cfg_wr_data;
      end

      rvld_r <= issue;
      if (cmd.accept || cmd.pick_init) begin
        iss_r <= '0;
      end else if (issue) begin
        iss_r <= iss_r + CNT_W'(1);
      end

      if (cmd.accept || cmd.pick_init) begin
        found_r <= 1'b0;
      end else if (cmd.pick_en && rvld_r && !found_r && (acc_sum > rem_r)) begin
        found_r <= 1'b1;
      end

      if (cmd.update && found_r && (new_remain == 16'd0) && (done_cnt_r != DONE_CNT_MAX)) begin
        done_cnt_r <= done_cnt_r + 5'd1;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (tick_r) begin
          time_r <= time_r + TIME_BITS'(1);
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= iss_r[IDX_W-1:0];

    if (cmd.accept) begin
      tick_r  <= in_data.command;
      dvd_r   <= in_data.random_value;
      total_r <= '0;
      busy_r  <= 1'b0;
      slot_r  <= 4'd0;
      fin_r   <= 1'b0;
      resp_r  <= 16'd0;
      turn_r  <= 16'd0;
    end else if (cmd.sum_en && rvld_r) begin
      total_r <= total_r + (rd_elig ? TOT_W'(rd_tickets) : TOT_W'(0));
    end

    if (cmd.div_start) begin
      rem_r     <= '0;
      div_cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      rem_r     <= div_diff[TOT_W] ? div_shift[TOT_W-1:0] : div_diff[TOT_W-1:0];
      dvd_r     <= {dvd_r[29:0], 1'b0};
      div_cnt_r <= div_cnt_r + 5'd1;
    end

    if (cmd.pick_init) begin
      acc_r <= '0;
    end else if (cmd.pick_en && rvld_r) begin
      acc_r <= acc_sum;
      if (!found_r && (acc_sum > rem_r)) begin
        pick_r      <= rd_idx_r;
        pick_word_r <= rd_data;
      end
    end

    if (cmd.update && found_r) begin
      busy_r <= 1'b1;
      slot_r <= pick_wide[3:0];
      fin_r  <= (new_remain == 16'd0);
      if (new_remain == 16'd0) begin
        resp_r <= resp_wide[15:0];
        turn_r <= turn_wide[15:0];
      end
    end

    if (cmd.emit) begin
      out_r.cpu_busy     <= busy_r;
      out_r.running_slot <= slot_r;
      out_r.finished     <= fin_r;
      out_r.resp_ticks   <= resp_r;
      out_r.turn_ticks   <= turn_r;
      out_r.all_done     <= (9'(done_cnt_r) >= n_wide);
      out_r.tick_time    <= time_wide[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/lottery_scheduler.sv]
// ----------------------------------------------------------------------------
// lottery_scheduler
// Lottery scheduler over a table of process slots.
//
// Input channel (in_valid/in_stall/in_data): a load transaction writes one
// slot's arrival time, burst length and tickets; a tick transaction carries
// a random draw and advances time by one tick. Every transaction yields one
// result on the output channel (out_valid/out_stall/out_data).
// cfg_wr_en/cfg_wr_data set the number of slots in use, to be written while idle (not enforced by the block).
// Steps: a load is accepted and then handed off; a tick with n >= 1 slots in use
// makes two passes over the slot table (ticket sum, then winner search) with a
// bit-serial modulo between them, then a slot update and the hand-off. With no
// eligible tickets the modulo, second pass and slot update drop.
// One transaction is in flight at a time; in_stall is high while it works.
// The result sits in an output register, so a new transaction is taken while
// the previous result waits; a stalled receiver holds out_data and, once the
// next result is ready, holds the block in its final step.
// Reset clears the tick counter, completion count and slot count; slot table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module lottery_scheduler
  import lsched_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  lsched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lsched_dp #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lottery_scheduler. An internal predictor keeps its
// own slot table, tick counter and completion count. It works out the grant
// record that each accepted load or tick transaction should produce, and a
// scoreboard compares every returned record field by field.
// The stimulus starts with a short directed set of cases. It then runs
// well-formed workloads mixed with random noise transactions under several
// slot counts, with random idling on both channels and one long output
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsched_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 100;
  localparam int SLOTS       = 16;

  class lottery_checker;
    logic [15:0] arr_tick  [SLOTS];
    logic [15:0] burst_len [SLOTS];
    logic [15:0] work_left [SLOTS];
    logic [15:0] first_run [SLOTS];
    logic [7:0]  tix       [SLOTS];
    logic [15:0] tick_now;
    int unsigned finished_cnt;
    logic [4:0]  slot_cnt;
    out_t        grant_q[$];
    int          errors;

    function new();
      tick_now     = '0;
      finished_cnt = 0;
      slot_cnt     = '0;
      errors       = 0;
    endfunction

    function void set_count(logic [4:0] v);
      slot_cnt = v;
    endfunction

    function int in_use();
      return (slot_cnt > SLOTS) ? SLOTS : int'(slot_cnt);
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function bit ready(int s);
      return (arr_tick[s] <= tick_now) && (work_left[s] != 16'd0);
    endfunction

    function void apply_txn(in_t t);
      out_t        g;
      int          n;
      int unsigned total;
      int unsigned sum;
      int unsigned win;
      int          pick;
      bit          hit;
      g = '0;
      n = in_use();
      g.tick_time = tick_now;
      if (t.command == CMD_LOAD) begin
        arr_tick[t.slot_index]  = t.arrive_at;
        burst_len[t.slot_index] = t.work_len;
        work_left[t.slot_index] = t.work_len;
        tix[t.slot_index]       = t.tickets;
      end else begin
        total = 0;
        for (int s = 0; s < n; s++) begin
          if (ready(s)) total += tix[s];
        end
        if (total > 0) begin
          win  = int'(t.random_value) % total;
          sum  = 0;
          pick = 0;
          hit  = 1'b0;
          for (int s = 0; s < n && !hit; s++) begin
            if (ready(s)) sum += tix[s];
            if (sum > win) begin
              pick = s;
              hit  = 1'b1;
            end
          end
          if (hit) begin
            g.cpu_busy     = 1'b1;
            g.running_slot = pick[3:0];
            if (work_left[pick] == burst_len[pick]) first_run[pick] = tick_now;
            work_left[pick] = work_left[pick] - 16'd1;
            if (work_left[pick] == 16'd0) begin
              g.finished   = 1'b1;
              g.resp_ticks = first_run[pick] - arr_tick[pick];
              g.turn_ticks = tick_now - arr_tick[pick];
              if (finished_cnt < 31) finished_cnt++;
            end
          end
        end
        tick_now = tick_now + 16'd1;
      end
      g.all_done = (finished_cnt >= n);
      grant_q.push_back(g);
    endfunction

    function void cmp_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_grant(out_t got);
      out_t e;
      if (grant_q.size() == 0) begin
        $error("result with no pending transaction");
        errors++;
        return;
      end
      e = grant_q.pop_front();
      cmp_field("cpu_busy", 32'(e.cpu_busy), 32'(got.cpu_busy));
      cmp_field("running_slot", 32'(e.running_slot), 32'(got.running_slot));
      cmp_field("finished", 32'(e.finished), 32'(got.finished));
      cmp_field("resp_ticks", 32'(e.resp_ticks), 32'(got.resp_ticks));
      cmp_field("turn_ticks", 32'(e.turn_ticks), 32'(got.turn_ticks));
      cmp_field("all_done", 32'(e.all_done), 32'(got.all_done));
      cmp_field("tick_time", 32'(e.tick_time), 32'(got.tick_time));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  lottery_checker sb;
  bit             quiet;
  int             items_sent;

  lottery_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [30:0] rand31();
    return 31'($urandom);
  endfunction

  function automatic in_t load_txn(logic [3:0] slot, logic [15:0] arr, logic [15:0] bur,
                                   logic [7:0] tk);
    in_t t;
    t.command      = CMD_LOAD;
    t.slot_index   = slot;
    t.arrive_at    = arr;
    t.work_len     = bur;
    t.tickets      = tk;
    t.random_value = rand31();
    return t;
  endfunction

  function automatic in_t tick_txn(logic [30:0] rv);
    in_t t;
    t.command      = CMD_TICK;
    t.slot_index   = 4'($urandom);
    t.arrive_at    = 16'($urandom);
    t.work_len     = 16'($urandom);
    t.tickets      = 8'($urandom);
    t.random_value = rv;
    return t;
  endfunction

  task automatic send_txn(in_t t);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.apply_txn(t);
    items_sent++;
  endtask

  task automatic set_slots(logic [4:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(v);
  endtask

  task automatic run_workload();
    int          n;
    int          work;
    int          b;
    logic [7:0]  tk;
    logic [15:0] base;
    n    = sb.in_use();
    base = sb.tick_now;
    work = 0;
    for (int s = 0; s < n; s++) begin
      b = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) tk = 8'd0;
      else if ($urandom_range(0, 9) == 0) tk = 8'hFF;
      else tk = 8'($urandom_range(1, 254));
      send_txn(load_txn(4'(s), base + 16'($urandom_range(0, 6)), 16'(b), tk));
      work += b;
    end
    repeat (work + $urandom_range(0, 8)) send_txn(tick_txn(rand31()));
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 1) begin
      send_txn(load_txn(4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
    end else begin
      send_txn(tick_txn(rand31()));
    end
  endtask

  initial begin
    logic [4:0] plan [7];
    sb          = new();
    quiet       = 1'b0;
    items_sent  = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_slots(5'd0);
    send_txn(tick_txn(31'h7FFF_FFFF));
    for (int s = 0; s < SLOTS; s++) begin
      case (s)
        0:       send_txn(load_txn(4'(s), 16'd0, 16'd2, 8'hFF));
        1:       send_txn(load_txn(4'(s), 16'd0, 16'd1, 8'd1));
        2:       send_txn(load_txn(4'(s), 16'd0, 16'd0, 8'd200));
        3:       send_txn(load_txn(4'(s), 16'd0, 16'd3, 8'd0));
        15:      send_txn(load_txn(4'(s), 16'hFFFF, 16'hFFFF, 8'hFF));
        default: send_txn(load_txn(4'(s), 16'(s % 3), 16'(1 + s % 2), 8'(16 * s + 3)));
      endcase
    end
    set_slots(5'd16);
    send_txn(tick_txn(31'd0));
    send_txn(tick_txn(31'h7FFF_FFFF));
    repeat (6) send_txn(tick_txn(rand31()));

    plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'($urandom_range(17, 30)),
             5'($urandom_range(2, 15)), 5'd16};
    for (int p = 0; p < 7; p++) begin
      set_slots(plan[p]);
      if (p == 6) quiet = 1'b1;
      while (items_sent < 25 + 147 * (p + 1)) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else run_workload();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lottery_scheduler verification clean");
    end else begin
      $display("lottery_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    int seen;
    bit held;
    stall_left = 0;
    seen       = 0;
    held       = 1'b0;
    out_stall  <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_grant(out_data);
        seen++;
      end
      if (stall_left == 0) begin
        if (!held && seen >= 150) begin
          held       = 1'b1;
          stall_left = 400;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 8);
        end
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("lottery_scheduler verification failed");
        $finish;
      end
    end
  end

endmodule

[sim.f]
rtl/lsched_pkg.sv
rtl/lsched_ram.sv
rtl/lsched_ctrl.sv
rtl/lsched_dp.sv
rtl/lottery_scheduler.sv
verif/testbench.sv
